>>> hw/rtl/arprr_pkg.sv
`default_nettype none

package arprr_pkg;

  localparam int unsigned MacW       = 48;
  localparam int unsigned IpW        = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PosW       = 6;
  localparam int unsigned CfgIndexW  = 8;
  localparam int unsigned CfgDataW   = 48;
  localparam int unsigned QueueDepth = 2;

  localparam logic [MacW-1:0] LocalMacReset = 48'd2277210749083;
  localparam logic [IpW-1:0]  LocalIpReset  = 32'd3232238082;

  localparam logic [CfgIndexW-1:0] CfgIdxLocalMac = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgIdxLocalIp  = 8'd1;

  localparam logic [PosW-1:0] PosMax      = 6'd63;
  localparam logic [PosW-1:0] PosArpLast  = 6'd41;
  localparam logic [PosW-1:0] ReplyLast   = 6'd59;

  typedef struct packed {
    logic [MacW-1:0] mac;
    logic [IpW-1:0]  ip;
  } req_t;

endpackage

`default_nettype wire

>>> hw/rtl/arprr_parser.sv
`default_nettype none

module arprr_parser (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        accept_i,
  input  wire [7:0]                  rx_byte_i,
  input  wire                        rx_last_i,
  input  wire [arprr_pkg::IpW-1:0]   local_ip_i,
  output logic                       push_o,
  output arprr_pkg::req_t            req_o
);
  import arprr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic            pass_q, pass_d;
  logic [MacW-1:0] mac_q, mac_d;
  logic [IpW-1:0]  ip_q, ip_d;
  logic            ok;
  logic            pass_now;

  always_comb begin
    ok = 1'b1;
    unique case (pos_q)
      6'd12: ok = (rx_byte_i == 8'h08);
      6'd13: ok = (rx_byte_i == 8'h06);
      6'd14: ok = (rx_byte_i == 8'h00);
      6'd15: ok = (rx_byte_i == 8'h01);
      6'd16: ok = (rx_byte_i == 8'h08);
      6'd17: ok = (rx_byte_i == 8'h00);
      6'd20: ok = (rx_byte_i == 8'h00);
      6'd21: ok = (rx_byte_i == 8'h01);
      6'd38: ok = (rx_byte_i == local_ip_i[31:24]);
      6'd39: ok = (rx_byte_i == local_ip_i[23:16]);
      6'd40: ok = (rx_byte_i == local_ip_i[15:8]);
      6'd41: ok = (rx_byte_i == local_ip_i[7:0]);
      default: ok = 1'b1;
    endcase
    pass_now = pass_q & ok;

    pos_d  = pos_q;
    pass_d = pass_q;
    mac_d  = mac_q;
    ip_d   = ip_q;
    push_o = 1'b0;
    if (accept_i) begin
      if ((pos_q >= 6'd22) && (pos_q <= 6'd27)) begin
        mac_d = {mac_q[MacW-9:0], rx_byte_i};
      end
      if ((pos_q >= 6'd28) && (pos_q <= 6'd31)) begin
        ip_d = {ip_q[IpW-9:0], rx_byte_i};
      end
      push_o = rx_last_i & pass_now & (pos_q >= PosArpLast);
      if (rx_last_i) begin
        pos_d  = '0;
        pass_d = 1'b1;
      end else begin
        pass_d = pass_now;
        if (pos_q != PosMax) begin
          pos_d = pos_q + 6'd1;
        end
      end
    end
    req_o.mac = mac_q;
    req_o.ip  = ip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pass_q <= 1'b1;
    end else begin
      pos_q  <= pos_d;
      pass_q <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mac_q <= mac_d;
    ip_q  <= ip_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/arprr_queue.sv
`default_nettype none

module arprr_queue #(
  parameter int unsigned Depth = arprr_pkg::QueueDepth
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  arprr_pkg::req_t  push_data_i,
  input  wire              pop_i,
  output arprr_pkg::req_t  head_o,
  output logic             empty_o,
  output logic             full_o
);
  import arprr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  req_t            entry_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntFull);
  assign head_o  = entry_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/arprr_tx.sv
`default_nettype none

module arprr_tx (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  arprr_pkg::req_t            head_i,
  input  wire                        empty_i,
  output logic                       pop_o,
  input  wire [arprr_pkg::MacW-1:0]  local_mac_i,
  input  wire [arprr_pkg::IpW-1:0]   local_ip_i,
  output logic                       tvalid_o,
  input  wire                        tready_i,
  output logic [7:0]                 tdata_o,
  output logic                       tlast_o
);
  import arprr_pkg::*;

  logic [PosW-1:0] cnt_q, cnt_d;
  logic            valid_q, valid_d;
  logic [7:0]      data_q, data_d;
  logic            last_q, last_d;
  logic            load;
  logic [7:0]      byte_val;

  function automatic logic [7:0] mac_sel(input logic [MacW-1:0] mac, input logic [2:0] k);
    logic [7:0] r;
    unique case (k)
      3'd0: r = mac[47:40];
      3'd1: r = mac[39:32];
      3'd2: r = mac[31:24];
      3'd3: r = mac[23:16];
      3'd4: r = mac[15:8];
      3'd5: r = mac[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ip_sel(input logic [IpW-1:0] ip, input logic [1:0] k);
    logic [7:0] r;
    unique case (k)
      2'd0: r = ip[31:24];
      2'd1: r = ip[23:16];
      2'd2: r = ip[15:8];
      2'd3: r = ip[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  always_comb begin
    byte_val = 8'h00;
    priority if (cnt_q < 6'd6) begin
      byte_val = mac_sel(head_i.mac, cnt_q[2:0]);
    end else if (cnt_q < 6'd12) begin
      byte_val = mac_sel(local_mac_i, 3'(cnt_q - 6'd6));
    end else if (cnt_q < 6'd22) begin
      unique case (cnt_q)
        6'd12:   byte_val = 8'h08;
        6'd13:   byte_val = 8'h06;
        6'd15:   byte_val = 8'h01;
        6'd16:   byte_val = 8'h08;
        6'd18:   byte_val = 8'h06;
        6'd19:   byte_val = 8'h04;
        6'd21:   byte_val = 8'h02;
        default: byte_val = 8'h00;
      endcase
    end else if (cnt_q < 6'd28) begin
      byte_val = mac_sel(local_mac_i, 3'(cnt_q - 6'd22));
    end else if (cnt_q < 6'd32) begin
      byte_val = ip_sel(local_ip_i, 2'(cnt_q - 6'd28));
    end else if (cnt_q < 6'd38) begin
      byte_val = mac_sel(head_i.mac, 3'(cnt_q - 6'd32));
    end else if (cnt_q < 6'd42) begin
      byte_val = ip_sel(head_i.ip, 2'(cnt_q - 6'd38));
    end else begin
      byte_val = 8'h00;
    end
  end

  always_comb begin
    load    = ~valid_q | tready_i;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = ~empty_i;
      data_d  = byte_val;
      last_d  = (cnt_q == ReplyLast);
      if (!empty_i) begin
        if (cnt_q == ReplyLast) begin
          cnt_d = '0;
          pop_o = 1'b1;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = data_q;
  assign tlast_o  = last_q;

endmodule

`default_nettype wire

>>> hw/rtl/arp_request_responder.sv
// An accepted request is queued, then the sender registers its reply bytes in the output stage.
// One byte in per cycle unless the queue is full; replies are 60 bytes out, one per ready cycle.
// A two-entry reply queue sits between parser and sender; input stalls only when it is full.
// Reset clears the parser, the queue and the output stage and loads the default addresses.
`default_nettype none

module arp_request_responder #(
  parameter int unsigned QueueDepth = arprr_pkg::QueueDepth
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire [7:0]                       s_axis_tdata,  // [7:0] rx_byte
  input  wire                             s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] tx_byte
  output logic                            m_axis_tlast,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [arprr_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire [arprr_pkg::CfgDataW-1:0]   cfg_data_i
);
  import arprr_pkg::*;

  logic [MacW-1:0] local_mac_q;
  logic [IpW-1:0]  local_ip_q;
  logic            rx_accept;
  logic            push, pop, empty, full;
  req_t            req, head;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~full;
  assign rx_accept     = s_axis_tvalid & ~full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_mac_q <= LocalMacReset;
      local_ip_q  <= LocalIpReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxLocalMac) begin
        local_mac_q <= cfg_data_i[MacW-1:0];
      end else if (cfg_index_i == CfgIdxLocalIp) begin
        local_ip_q <= cfg_data_i[IpW-1:0];
      end
    end
  end

  arprr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (rx_accept),
    .rx_byte_i  (s_axis_tdata),
    .rx_last_i  (s_axis_tlast),
    .local_ip_i (local_ip_q),
    .push_o     (push),
    .req_o      (req)
  );

  arprr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (req),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  arprr_tx u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .local_mac_i (local_mac_q),
    .local_ip_i  (local_ip_q),
    .tvalid_o    (m_axis_tvalid),
    .tready_i    (m_axis_tready),
    .tdata_o     (m_axis_tdata),
    .tlast_o     (m_axis_tlast)
  );

endmodule

`default_nettype wire
